@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// Move-to-front list package
// Widths, register map, beat types and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    localparam int ITEM_W = 7;
    localparam int CNT_W  = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] COUNT_RST = 7'd64;

    localparam logic [APB_AW-3:0] REG_ITEM_COUNT = 1'b0;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ITEM_W-1:0] item;
    } t_in_beat;

    typedef struct packed {
        logic [ITEM_W-1:0] item_res;
        logic              last;
    } t_out_beat;

    typedef struct packed {
        logic load_move;
        logic mv1;
        logic mv2;
        logic mv3;
        logic dump_start;
        logic dump_emit;
    } t_mtf_cmd;

    typedef struct packed {
        logic is_dump;
        logic move_ok;
        logic slot_free;
        logic dump_last;
    } t_mtf_sts;

endpackage

`default_nettype wire

@@ hdl/mtf_chan_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel
// One beat per edge with valid and ready high; payload type set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtf_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/mtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Move-to-front controller
// Sequences link updates of a move and the walk of a dump.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mtf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mtf_pkg::t_mtf_sts i_sts,
    output mtf_pkg::t_mtf_cmd      o_cmd
);
    import mtf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MV1  = 3'd1;
    localparam logic [2:0] ST_MV2  = 3'd2;
    localparam logic [2:0] ST_MV3  = 3'd3;
    localparam logic [2:0] ST_DUMP = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_sts.is_dump) begin
                        o_cmd.dump_start = 1'b1;
                        n_state          = ST_DUMP;
                    end else if (i_sts.move_ok) begin
                        o_cmd.load_move = 1'b1;
                        n_state         = ST_MV1;
                    end
                end
            end
            ST_MV1: begin
                o_cmd.mv1 = 1'b1;
                n_state   = ST_MV2;
            end
            ST_MV2: begin
                o_cmd.mv2 = 1'b1;
                n_state   = ST_MV3;
            end
            ST_MV3: begin
                o_cmd.mv3 = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_DUMP: begin
                if (i_sts.slot_free) begin
                    o_cmd.dump_emit = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_mv_seq, i_clk, i_rst_n, r_state == ST_MV1, r_state == ST_MV2, "move sequence broken")
    `ASSERT_NEXT(a_dump_end, i_clk, i_rst_n, o_cmd.dump_emit && i_sts.dump_last, r_state == ST_IDLE, "dump did not end on last beat")

endmodule

`default_nettype wire

@@ hdl/mtf_dp.sv @@
// ----------------------------------------------------------------------------
// Move-to-front datapath
// Link memories with per-entry valid bits, head/tail, dump walk, out register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mtf_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mtf_pkg::t_mtf_cmd               i_cmd,
    output mtf_pkg::t_mtf_sts                    o_sts,
    input  wire mtf_pkg::t_in_beat               i_in_beat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output mtf_pkg::t_out_beat                   o_out_beat,
    input  wire logic                            i_cfg_we,
    input  wire logic [mtf_pkg::CNT_W-1:0]       i_cfg_data,
    output logic [mtf_pkg::CNT_W-1:0]            o_count
);
    import mtf_pkg::*;

    localparam int                IDX_W   = $clog2(MAX_ITEMS);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_ITEMS);

    function automatic logic [CNT_W-1:0] f_clamp(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > MAX_CNT) begin
            r = MAX_CNT;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] f_idx(input logic [ITEM_W-1:0] it);
        logic [ITEM_W-1:0] t;
        t = it - ITEM_W'(1);
        return t[IDX_W-1:0];
    endfunction

    logic [ITEM_W-1:0] r_next_mem [MAX_ITEMS];
    logic [ITEM_W-1:0] r_prev_mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_next_vld;
    logic [MAX_ITEMS-1:0] r_prev_vld;

    logic [ITEM_W-1:0] r_next_rd;
    logic [ITEM_W-1:0] r_prev_rd;
    logic              r_next_rv;
    logic              r_prev_rv;
    logic [IDX_W-1:0]  r_next_ri;
    logic [IDX_W-1:0]  r_prev_ri;

    logic [CNT_W-1:0]  r_count;
    logic [ITEM_W-1:0] r_head;
    logic [ITEM_W-1:0] r_tail;
    logic [ITEM_W-1:0] r_x;
    logic              r_first;
    logic [CNT_W-1:0]  r_k;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [CNT_W-1:0]  n_act;
    logic [ITEM_W-1:0] ri_item;
    logic [ITEM_W-1:0] next_eff;
    logic [ITEM_W-1:0] prev_eff;
    logic [ITEM_W-1:0] cur;

    logic              next_we;
    logic [IDX_W-1:0]  next_wa;
    logic [ITEM_W-1:0] next_wd;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_wa;
    logic [ITEM_W-1:0] prev_wd;
    logic              next_re;
    logic [IDX_W-1:0]  next_ra;
    logic              prev_re;
    logic [IDX_W-1:0]  prev_ra;

    assign n_act    = f_clamp(r_count);
    assign ri_item  = ITEM_W'(r_next_ri) + ITEM_W'(1);
    assign next_eff = r_next_rv ? r_next_rd
                    : ((ri_item < n_act) ? ri_item + ITEM_W'(1) : '0);
    assign prev_eff = r_prev_rv ? r_prev_rd : ITEM_W'(r_prev_ri);
    assign cur      = r_first ? r_head : next_eff;

    assign o_sts.is_dump   = (i_in_beat.kind == KIND_DUMP);
    assign o_sts.move_ok   = (i_in_beat.item != '0) && (i_in_beat.item <= n_act)
                          && (i_in_beat.item != r_head);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.dump_last = (r_k == n_act - CNT_W'(1));

    assign next_re = i_cmd.load_move || i_cmd.dump_emit;
    assign next_ra = i_cmd.load_move ? f_idx(i_in_beat.item) : f_idx(cur);
    assign prev_re = i_cmd.load_move;
    assign prev_ra = f_idx(i_in_beat.item);

    // link rewrites: prev_eff is the predecessor, next_eff the successor
    always_comb begin
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        if (i_cmd.mv1) begin
            next_we = 1'b1;
            next_wa = f_idx(prev_eff);
            next_wd = next_eff;
            prev_we = 1'b1;
            prev_wa = f_idx(r_x);
            prev_wd = '0;
        end else if (i_cmd.mv2) begin
            next_we = 1'b1;
            next_wa = f_idx(r_x);
            next_wd = r_head;
            prev_we = (r_x != r_tail);
            prev_wa = f_idx(next_eff);
            prev_wd = prev_eff;
        end else if (i_cmd.mv3) begin
            prev_we = 1'b1;
            prev_wa = f_idx(r_head);
            prev_wd = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (next_re) begin
            r_next_rd <= r_next_mem[next_ra];
            r_next_rv <= r_next_vld[next_ra];
            r_next_ri <= next_ra;
        end
        if (prev_re) begin
            r_prev_rd <= r_prev_mem[prev_ra];
            r_prev_rv <= r_prev_vld[prev_ra];
            r_prev_ri <= prev_ra;
        end
        if (i_cmd.load_move) begin
            r_x <= i_in_beat.item;
        end
        if (i_cmd.dump_emit) begin
            r_out.item_res <= cur;
            r_out.last     <= o_sts.dump_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RST;
            r_head      <= ITEM_W'(1);
            r_tail      <= ITEM_W'(f_clamp(COUNT_RST));
            r_next_vld  <= '0;
            r_prev_vld  <= '0;
            r_first     <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count    <= i_cfg_data;
                r_head     <= ITEM_W'(1);
                r_tail     <= ITEM_W'(f_clamp(i_cfg_data));
                r_next_vld <= '0;
                r_prev_vld <= '0;
            end else begin
                if (next_we) begin
                    r_next_vld[next_wa] <= 1'b1;
                end
                if (prev_we) begin
                    r_prev_vld[prev_wa] <= 1'b1;
                end
                if (i_cmd.mv3) begin
                    r_head <= r_x;
                    if (r_x == r_tail) begin
                        r_tail <= prev_eff;
                    end
                end
            end
            if (i_cmd.dump_start) begin
                r_first <= 1'b1;
                r_k     <= '0;
            end else if (i_cmd.dump_emit) begin
                r_first <= 1'b0;
                r_k     <= r_k + CNT_W'(1);
            end
            if (i_cmd.dump_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_count     = r_count;

    `ASSERT_ALWAYS(a_head_range, i_clk, i_rst_n, (r_head != '0) && (r_head <= n_act), "head out of range")
    `ASSERT_IMPL(a_emit_slot, i_clk, i_rst_n, i_cmd.dump_emit, !r_out_valid || i_out_ready, "dump beat overwrites pending output")

endmodule

`default_nettype wire

@@ hdl/move_to_front_list.sv @@
// ----------------------------------------------------------------------------
// Move-to-front list
// Ordered list of items 1..N as a doubly linked list; move to front, dump.
//
//   channel   dir   beat / access             fields
//   i_in      in    valid/ready               kind, item
//   o_out     out   valid/ready               item_res, last
//   apb       in    psel/penable, pready=1    item_count at 0x0
//
// A move is accepted with link reads, then writes links in states MV1, MV2, MV3.
// An ignored move (bad item or head item) is accepted with no link writes.
// A dump is accepted to start the walk, then gives one beat per cycle from
// the next link memory read port while o_out is not stalled; a stall holds
// the walk. Reset and an item_count write clear the link valid bits together;
// no clearing pass, the block accepts the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_list #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    mtf_chan_if.sink                          i_in,
    mtf_chan_if.source                        o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mtf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mtf_pkg::APB_DW-1:0]   pwdata,
    output logic [mtf_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import mtf_pkg::*;

    t_in_beat         in_beat;
    t_out_beat        out_beat;
    t_mtf_cmd         cmd;
    t_mtf_sts         sts;
    logic             in_ready;
    logic             out_valid;
    logic             reg_hit;
    logic             cfg_we;
    logic [CNT_W-1:0] count;

    assign in_beat.kind = i_in.data.kind;
    assign in_beat.item = i_in.data.item;
    assign i_in.ready   = in_ready;

    assign o_out.valid         = out_valid;
    assign o_out.data.item_res = out_beat.item_res;
    assign o_out.data.last     = out_beat.last;

    assign reg_hit = (paddr[APB_AW-1:2] == REG_ITEM_COUNT);
    assign cfg_we  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {(APB_DW-CNT_W)'(0), count} : '0;

    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtf_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_beat   (in_beat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (pwdata[CNT_W-1:0]),
        .o_count     (count)
    );

endmodule

`default_nettype wire

@@ dv/tb_move_to_front_list.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Move-to-front list testbench
// Drives move and dump requests over the valid/ready input channel, with
// item_count set through the APB port between phases. A tracker keeps its
// own linked list and checks every dump beat against it.
// ----------------------------------------------------------------------------

class mtf_order_tracker;
    localparam int LIST_MAX = 64;

    typedef logic [mtf_pkg::ITEM_W-1:0] t_item;

    t_item                      next_of [1:LIST_MAX];
    t_item                      prev_of [1:LIST_MAX];
    t_item                      head_item;
    t_item                      tail_item;
    logic [mtf_pkg::CNT_W-1:0]  count_reg;
    mtf_pkg::t_out_beat         pending_order[$];
    int                         errors;

    function new();
        errors = 0;
        count_reg = mtf_pkg::COUNT_RST;
        rebuild();
    endfunction

    function int active();
        int n = count_reg;
        if (n < 1) n = 1;
        if (n > LIST_MAX) n = LIST_MAX;
        return n;
    endfunction

    function bit in_list(int x);
        return x >= 1 && x <= active();
    endfunction

    function void rebuild();
        int n = active();
        for (int i = 1; i <= LIST_MAX; i++) begin
            next_of[i] = t_item'((i < n) ? i + 1 : 0);
            prev_of[i] = t_item'((i <= n) ? i - 1 : 0);
        end
        head_item = t_item'(1);
        tail_item = t_item'(n);
    endfunction

    function void write_reg(logic [mtf_pkg::APB_AW-3:0] idx, logic [31:0] value);
        if (idx != mtf_pkg::REG_ITEM_COUNT) return;
        count_reg = value[mtf_pkg::CNT_W-1:0];
        rebuild();
    endfunction

    function void move_front(int x);
        int p;
        int nx;
        if (!in_list(x) || x == head_item) return;
        p  = prev_of[x];
        nx = next_of[x];
        if (in_list(p)) next_of[p] = t_item'(nx);
        if (x == tail_item) tail_item = t_item'(p);
        else if (in_list(nx)) prev_of[nx] = t_item'(p);
        prev_of[x] = t_item'(0);
        next_of[x] = head_item;
        if (in_list(head_item)) prev_of[head_item] = t_item'(x);
        head_item = t_item'(x);
    endfunction

    function void note_request(mtf_pkg::t_in_beat req);
        mtf_pkg::t_out_beat walk[$];
        mtf_pkg::t_out_beat beat;
        int cur;
        int n;
        if (req.kind == mtf_pkg::KIND_MOVE) begin
            move_front(req.item);
            return;
        end
        n = active();
        cur = head_item;
        while (walk.size() < n && in_list(cur)) begin
            beat.item_res = t_item'(cur);
            beat.last = 1'b0;
            walk.push_back(beat);
            cur = next_of[cur];
        end
        if (walk.size() > 0) walk[walk.size()-1].last = 1'b1;
        foreach (walk[i]) pending_order.push_back(walk[i]);
    endfunction

    function void check_beat(mtf_pkg::t_out_beat got);
        mtf_pkg::t_out_beat want;
        if (pending_order.size() == 0) begin
            errors++;
            $display("%0t: unexpected dump beat, expected none, actual item_res %0d last %0b",
                     $time, got.item_res, got.last);
            return;
        end
        want = pending_order.pop_front();
        if (got.item_res !== want.item_res) begin
            errors++;
            $display("%0t: item_res mismatch, expected %0d, actual %0d",
                     $time, want.item_res, got.item_res);
        end
        if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, got.last);
        end
    endfunction
endclass

module tb_move_to_front_list;
    import mtf_pkg::*;

    localparam logic [APB_AW-3:0] REG_SPARE = 1'b1;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    mtf_order_tracker tracker = new();

    mtf_chan_if #(.T(t_in_beat))  req_ch ();
    mtf_chan_if #(.T(t_out_beat)) ord_ch ();

    move_to_front_list #(.MAX_ITEMS(64)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (ord_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("move_to_front_list verification failed");
        $finish;
    end

    initial begin
        ord_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && ord_ch.valid && ord_ch.ready) tracker.check_beat(ord_ch.data);
            ord_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_req(input t_in_beat req);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        do @(posedge clk); while (!req_ch.ready);
        tracker.note_request(req);
    endtask

    task automatic do_move(input int x);
        t_in_beat req;
        req.kind = KIND_MOVE;
        req.item = ITEM_W'(x);
        send_req(req);
    endtask

    task automatic do_dump();
        t_in_beat req;
        req.kind = KIND_DUMP;
        req.item = ITEM_W'($urandom_range(127));
        send_req(req);
    endtask

    // drop valid, drain the dump beats, then cover a move still in flight
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.pending_order.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [APB_AW-3:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    task automatic run_mix(input int beats);
        t_in_beat req;
        int r;
        int n;
        for (int i = 0; i < beats; i++) begin
            n = tracker.active();
            r = $urandom_range(99);
            req.kind = KIND_MOVE;
            req.item = ITEM_W'($urandom_range(n, 1));
            if (r < 12) begin
                req.kind = KIND_DUMP;
                req.item = ITEM_W'($urandom_range(127));
            end else if (r < 18) begin
                req.item = ITEM_W'((r < 15) ? 0 : $urandom_range(127, n + 1));
            end else if (r < 30) begin
                req.item = tracker.head_item;
            end else if (r < 42) begin
                req.item = tracker.tail_item;
            end
            send_req(req);
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // full list out of reset: head, tail, out-of-range and middle moves
        do_dump();
        do_move(1);
        do_move(64);
        do_move(0);
        do_move(127);
        do_move(65);
        do_move(32);
        do_move(63);
        do_dump();

        settle();
        cfg_write(REG_ITEM_COUNT, 1);
        do_dump();
        do_move(1);
        do_move(2);
        do_move(127);
        do_dump();

        settle();
        cfg_write(REG_ITEM_COUNT, 2);
        do_move(2);
        do_dump();
        do_move(1);
        do_dump();

        settle();
        cfg_write(REG_ITEM_COUNT, 0);
        do_dump();

        settle();
        cfg_write(REG_ITEM_COUNT, 127);
        do_move(64);
        do_dump();

        settle();
        cfg_write(REG_SPARE, 5);
        do_dump();

        settle();
        cfg_write(REG_ITEM_COUNT, 64);
        run_mix(60);

        settle();
        cfg_write(REG_ITEM_COUNT, 3);
        src_idle_pct = 47;
        run_mix(60);

        settle();
        cfg_write(REG_ITEM_COUNT, $urandom_range(63, 4));
        src_idle_pct   = 0;
        sink_stall_pct = 47;
        run_mix(65);

        settle();
        cfg_write(REG_ITEM_COUNT, 16);
        src_idle_pct   = 22;
        sink_stall_pct = 22;
        run_mix(65);

        settle();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("move_to_front_list verification clean");
        end else begin
            $display("move_to_front_list verification failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mtf_pkg.sv
hdl/mtf_chan_if.sv
hdl/mtf_ctrl.sv
hdl/mtf_dp.sv
hdl/move_to_front_list.sv
dv/tb_move_to_front_list.sv
